// ===== hdl/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants for the ray/box slab test: default coordinate width and
// configuration register indexes.
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int NUM_REGS       = 6;
	localparam int CFG_ADDR_BITS  = 3;
	localparam int NUM_AXES       = 3;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} reg_idx_t;

endpackage

// ===== hdl/rbst_axis.sv =====
// ----------------------------------------------------------------------------
// rbst_axis
// One axis of the slab test: plane distances and direction (stage 1), then
// sign-normalized entry/exit numerators and denominator (stage 2).
// ----------------------------------------------------------------------------
module rbst_axis #(
	parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] p,
	input  logic signed [COORD_BITS-1:0] q,
	input  logic signed [COORD_BITS-1:0] lo,
	input  logic signed [COORD_BITS-1:0] hi,
	output logic signed [COORD_BITS+1:0] enter_s2,
	output logic signed [COORD_BITS+1:0] leave_s2,
	output logic signed [COORD_BITS+1:0] den_s2,
	output logic                         bnd_s2,
	output logic                         fail_s2
);

	localparam int DW = COORD_BITS + 1;
	localparam int NW = COORD_BITS + 2;

	logic signed [DW-1:0] d_s1, n1_s1, n2_s1;
	logic signed [NW-1:0] n1x, n2x, dx, n1a, n2a, da;
	logic                 neg;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= DW'(q) - DW'(p);
			n1_s1 <= DW'(lo) - DW'(p);
			n2_s1 <= DW'(hi) - DW'(p);
		end
	end

	// flip the axis when the direction is negative so the denominator is positive
	always_comb begin
		n1x = NW'(n1_s1);
		n2x = NW'(n2_s1);
		dx  = NW'(d_s1);
		neg = d_s1[DW-1];
		n1a = neg ? -n1x : n1x;
		n2a = neg ? -n2x : n2x;
		da  = neg ? -dx  : dx;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			enter_s2 <= (n1a < n2a) ? n1a : n2a;
			leave_s2 <= (n1a < n2a) ? n2a : n1a;
			den_s2   <= da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_s2  <= 1'b0;
			fail_s2 <= 1'b0;
		end else if (en) begin
			bnd_s2  <= (d_s1 != '0);
			// zero direction: origin must sit between the planes
			fail_s2 <= (d_s1 == '0) && ((n1_s1 > 0) || (n2_s1 < 0));
		end
	end

endmodule

// ===== hdl/rbst_cross.sv =====
// ----------------------------------------------------------------------------
// rbst_cross
// Interval overlap: every entry of one axis against every exit of another,
// by exact cross products (stage 3), then compare and reduce (stage 4).
// ----------------------------------------------------------------------------
module rbst_cross #(
	parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic signed [COORD_BITS+1:0] enter_s2 [rbst_pkg::NUM_AXES],
	input  logic signed [COORD_BITS+1:0] leave_s2 [rbst_pkg::NUM_AXES],
	input  logic signed [COORD_BITS+1:0] den_s2   [rbst_pkg::NUM_AXES],
	input  logic [rbst_pkg::NUM_AXES-1:0] bnd_s2,
	input  logic [rbst_pkg::NUM_AXES-1:0] fail_s2,
	output logic                         hit_s4
);

	localparam int NA = rbst_pkg::NUM_AXES;
	localparam int PW = 2 * (COORD_BITS + 2);

	logic signed [PW-1:0] lhs_s3 [NA][NA];
	logic signed [PW-1:0] rhs_s3 [NA][NA];
	logic [NA-1:0]        bnd_s3, lneg_s3;
	logic                 fail_s3;
	logic [NA*NA-1:0]     pair_ok;

	for (genvar i = 0; i < NA; i++) begin : g_i
		for (genvar j = 0; j < NA; j++) begin : g_j
			if (i != j) begin : g_pair
				// enter_i/den_i <= leave_j/den_j  <=>  enter_i*den_j <= leave_j*den_i
				always_ff @(posedge clk) begin
					if (en) begin
						lhs_s3[i][j] <= PW'(enter_s2[i]) * PW'(den_s2[j]);
						rhs_s3[i][j] <= PW'(leave_s2[j]) * PW'(den_s2[i]);
					end
				end
				assign pair_ok[i*NA+j] = !(bnd_s3[i] && bnd_s3[j]) ||
					(lhs_s3[i][j] <= rhs_s3[i][j]);
			end else begin : g_self
				assign pair_ok[i*NA+j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_s3  <= '0;
			lneg_s3 <= '0;
			fail_s3 <= 1'b0;
			hit_s4  <= 1'b0;
		end else if (en) begin
			bnd_s3 <= bnd_s2;
			for (int k = 0; k < NA; k++) begin
				lneg_s3[k] <= bnd_s2[k] && leave_s2[k][COORD_BITS+1];
			end
			fail_s3 <= |fail_s2;
			hit_s4  <= !fail_s3 && (lneg_s3 == '0) && (&pair_ok);
		end
	end

endmodule

// ===== hdl/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Exact slab-method test of a ray against an axis-aligned box.
// ----------------------------------------------------------------------------
// The block takes one request per cycle when the output is not stalled
// (origin and a second point on the ray) and returns one hit bit per
// request, in order. The result shows on the output after the request has
// passed the four register stages: plane distances and direction,
// sign-normalized entry/exit fractions, exact cross products, and the
// compare/reduce into the hit bit. All six box corners reset to zero.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so s_tready follows m_tready. The hit is 1 when every axis
// with zero direction has the origin inside its slab and the intervals of
// the other axes overlap at a parameter >= 0 (the ray is not clipped at the
// second point). The user must write the box corners over cfg_we/cfg_addr/
// cfg_data only while no request is in flight; the block does not check it.
module ray_box_slab_test #(
	parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF,
	localparam int IN_BITS = 6 * COORD_BITS,
	localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// origin_x, origin_y, origin_z, target_x, target_y, target_z (low bits up)
	input  logic [IN_TDATA_BITS-1:0]          s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit in bit 0, zeros above
	output logic [7:0]                        m_tdata,
	input  logic                              cfg_we,
	input  logic [rbst_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [COORD_BITS-1:0]             cfg_data
);

	localparam int NA = rbst_pkg::NUM_AXES;

	logic [COORD_BITS-1:0] box_min_q [NA];
	logic [COORD_BITS-1:0] box_max_q [NA];

	logic                         adv;
	logic                         v_s1, v_s2, v_s3, v_s4;
	logic signed [COORD_BITS+1:0] enter_s2 [NA];
	logic signed [COORD_BITS+1:0] leave_s2 [NA];
	logic signed [COORD_BITS+1:0] den_s2   [NA];
	logic [NA-1:0]                bnd_s2, fail_s2;
	logic                         hit_s4;

	// box registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NA; k++) begin
				box_min_q[k] <= '0;
				box_max_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_addr)
				rbst_pkg::REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				rbst_pkg::REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				rbst_pkg::REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				rbst_pkg::REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				rbst_pkg::REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				rbst_pkg::REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance every stage together when the output slot is free or being taken
	assign adv      = !v_s4 || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	for (genvar a = 0; a < NA; a++) begin : g_axis
		rbst_axis #(.COORD_BITS(COORD_BITS)) u_axis (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.p        (s_tdata[a*COORD_BITS +: COORD_BITS]),
			.q        (s_tdata[(a+NA)*COORD_BITS +: COORD_BITS]),
			.lo       (box_min_q[a]),
			.hi       (box_max_q[a]),
			.enter_s2 (enter_s2[a]),
			.leave_s2 (leave_s2[a]),
			.den_s2   (den_s2[a]),
			.bnd_s2   (bnd_s2[a]),
			.fail_s2  (fail_s2[a])
		);
	end

	rbst_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.enter_s2 (enter_s2),
		.leave_s2 (leave_s2),
		.den_s2   (den_s2),
		.bnd_s2   (bnd_s2),
		.fail_s2  (fail_s2),
		.hit_s4   (hit_s4)
	);

	assign m_tvalid = v_s4;
	assign m_tdata  = {7'b0, hit_s4};

	// a held pipeline keeps its occupancy
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4}))
		else $error("pipeline occupancy changed while stalled");

	// a request in stage 3 reaches the output on the next advance
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 |=> m_tvalid)
		else $error("result lost between stage 3 and output");

	// input is refused only while a result waits on a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input refused without output back-pressure");

endmodule

// ===== tb/ray_box_slab_test_tb.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test_tb
// Self-checking bench for the exact ray/box slab test.
// ----------------------------------------------------------------------------
// Rays are streamed into the block under several box settings. The expected
// hit bit of each ray comes from an exact rational model of the slab test in
// the bench. Results are compared in order against the expectations.
// ----------------------------------------------------------------------------
module ray_box_slab_test_tb;

	localparam int CB    = rbst_pkg::COORD_BITS_DEF;
	localparam int TDW   = ((6 * CB + 7) / 8) * 8;
	localparam int LAT   = 4;
	localparam int NRAND = 1750;

	typedef logic signed [CB-1:0] coord_t;
	typedef struct packed {
		coord_t tz, ty, tx, oz, oy, ox;
	} ray_t;

	// Fraction num/den, den > 0; 64 bits hold every difference exactly.
	typedef struct {
		longint num;
		longint den;
	} frac_t;

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [TDW-1:0]  s_tdata;
	logic            m_tvalid;
	logic            m_tready;
	logic [7:0]      m_tdata;
	logic            cfg_we;
	logic [rbst_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CB-1:0]   cfg_data;

	coord_t box_lo [3];
	coord_t box_hi [3];

	ray_t   ray_queue [$];
	logic   hit_queue [$];
	int     mismatches;
	int     hits_seen, results_seen;
	int     hold_off;      // cycles left in a long receiver stall
	int     burst_left, gap_left;
	bit     driving;
	bit     taken;         // the offered request went in at the last rising edge

	ray_box_slab_test #(.COORD_BITS(CB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sign of a - b; products fit in 128 bits signed.
	function automatic int frac_cmp(frac_t a, frac_t b);
		logic signed [127:0] l, r;
		l = 128'(signed'(a.num)) * 128'(signed'(b.den));
		r = 128'(signed'(b.num)) * 128'(signed'(a.den));
		return (l < r) ? -1 : ((l > r) ? 1 : 0);
	endfunction

	function automatic logic slab_hit(ray_t r);
		coord_t org [3];
		coord_t tgt [3];
		bit     in_box, bounded;
		frac_t  t_in, t_out, e, x;
		longint p, d, n1, n2;
		org = '{r.ox, r.oy, r.oz};
		tgt = '{r.tx, r.ty, r.tz};
		in_box = 1; bounded = 0;
		t_in = '{0, 1}; t_out = '{0, 1};
		for (int ax = 0; ax < 3; ax++) begin
			p = org[ax];
			d = longint'(tgt[ax]) - p;
			if (d == 0) begin
				if (p < box_lo[ax] || p > box_hi[ax])
					in_box = 0;
			end else begin
				n1 = box_lo[ax] - p;
				n2 = box_hi[ax] - p;
				if (d < 0) begin
					n1 = -n1; n2 = -n2; d = -d;
				end
				e = '{(n1 < n2) ? n1 : n2, d};
				x = '{(n1 < n2) ? n2 : n1, d};
				if (!bounded) begin
					t_in = e; t_out = x; bounded = 1;
				end else begin
					if (frac_cmp(e, t_in) > 0) t_in = e;
					if (frac_cmp(x, t_out) < 0) t_out = x;
				end
			end
		end
		return in_box && (!bounded || (t_out.num >= 0 && frac_cmp(t_in, t_out) <= 0));
	endfunction

	// Driver: bursts of requests with random gaps; hold valid until taken.
	always @(negedge clk) begin
		if (!arst_n || !driving) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || taken) begin
			// previous request taken or none offered: pick the next one
			taken = 1'b0;
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (ray_queue.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= TDW'(ray_queue[0]);
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					if ($urandom_range(0, 3) != 0) gap_left = $urandom_range(0, 6);
				end else begin
					burst_left = burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Predict at acceptance so ordering matches the stream; retire the request.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			hit_queue.push_back(slab_hit(ray_t'(s_tdata[6*CB-1:0])));
			void'(ray_queue.pop_front());
			taken = 1'b1;
		end
	end

	// Receiver stall pattern, with the occasional long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off = hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 99) < 30);
		end
	end

	// Monitor: compare each result with the oldest expectation.
	always @(posedge clk) begin
		logic want;
		if (arst_n && m_tvalid && m_tready) begin
			if (hit_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result m_tdata=%h", m_tdata);
			end else begin
				want = hit_queue.pop_front();
				results_seen++;
				hits_seen += want;
				if (m_tdata !== {7'd0, want}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("hit mismatch: expected %0d got %h", want, m_tdata);
				end
			end
		end
	end

	task automatic write_reg(rbst_pkg::reg_idx_t idx, coord_t val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic set_box(coord_t lx, coord_t ly, coord_t lz, coord_t hx, coord_t hy,
			coord_t hz);
		write_reg(rbst_pkg::REG_BOX_MIN_X, lx); box_lo[0] = lx;
		write_reg(rbst_pkg::REG_BOX_MIN_Y, ly); box_lo[1] = ly;
		write_reg(rbst_pkg::REG_BOX_MIN_Z, lz); box_lo[2] = lz;
		write_reg(rbst_pkg::REG_BOX_MAX_X, hx); box_hi[0] = hx;
		write_reg(rbst_pkg::REG_BOX_MAX_Y, hy); box_hi[1] = hy;
		write_reg(rbst_pkg::REG_BOX_MAX_Z, hz); box_hi[2] = hz;
	endtask

	// Coordinate near the box (to make hits common) or anywhere.
	function automatic coord_t pick(int ax, bit wide);
		longint c;
		if (wide || $urandom_range(0, 9) == 0)
			return coord_t'($urandom);
		c = (longint'(box_lo[ax]) + box_hi[ax]) / 2 + $signed($urandom_range(0, 400)) - 200;
		if ($urandom_range(0, 3) == 0)
			c = ($urandom_range(0, 1)) ? longint'(box_lo[ax]) : longint'(box_hi[ax]);
		return coord_t'(c);
	endfunction

	function automatic ray_t random_ray(bit wide);
		ray_t r;
		r.ox = pick(0, wide); r.oy = pick(1, wide); r.oz = pick(2, wide);
		r.tx = pick(0, wide); r.ty = pick(1, wide); r.tz = pick(2, wide);
		// flatten some axes to exercise the zero-direction path
		if ($urandom_range(0, 4) == 0) r.tx = r.ox;
		if ($urandom_range(0, 4) == 0) r.ty = r.oy;
		if ($urandom_range(0, 4) == 0) r.tz = r.oz;
		return r;
	endfunction

	// Drain: wait until every request is sent and answered, then settle.
	task automatic drain();
		while (ray_queue.size() != 0 || hit_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};

	initial begin
		ray_t r;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_data = '0;
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		mismatches = 0; hits_seen = 0; results_seen = 0; hold_off = 0;
		burst_left = 0; gap_left = 0; driving = 0; taken = 0;
		for (int i = 0; i < 3; i++) begin box_lo[i] = '0; box_hi[i] = '0; end
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		driving = 1;

		// Directed: reset box (a point), field extremes, axis-parallel rays,
		// all-zero direction in and out, inverted box.
		ray_queue.push_back('0);
		ray_queue.push_back('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
		ray_queue.push_back('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});
		ray_queue.push_back('{-24'sd1, -24'sd1, -24'sd1, 24'sd1, 24'sd1, 24'sd1});
		ray_queue.push_back('{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd5});
		drain();
		set_box(-24'sd100, -24'sd100, -24'sd100, 24'sd100, 24'sd100, 24'sd100);
		ray_queue.push_back('{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0});
		ray_queue.push_back('{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd101});
		ray_queue.push_back('{24'sd0, 24'sd0, 24'sd300, 24'sd0, 24'sd0, -24'sd300});
		ray_queue.push_back('{24'sd0, 24'sd0, -24'sd300, 24'sd0, 24'sd0, -24'sd200});
		ray_queue.push_back('{24'sd100, 24'sd100, 24'sd100, 24'sd200, 24'sd200, 24'sd200});
		ray_queue.push_back('{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd100, 24'sd100});
		ray_queue.push_back('{24'sd0, 24'sd300, 24'sd301, 24'sd0, 24'sd99, 24'sd100});
		ray_queue.push_back('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
		drain();
		set_box(24'sd50, 24'sd50, 24'sd50, -24'sd50, -24'sd50, -24'sd50);
		ray_queue.push_back('{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0});
		ray_queue.push_back('{24'sd1, 24'sd1, 24'sd1, -24'sd200, -24'sd200, -24'sd200});
		ray_queue.push_back('{24'sd0, 24'sd1, 24'sd1, 24'sd0, -24'sd200, -24'sd200});
		drain();

		// Random phases over several boxes, extremes among them.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
			0: set_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
			1: set_box(-24'sd1000, -24'sd2000, 24'sd10, 24'sd1000, 24'sd30, 24'sd5000);
			2: set_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
			default: begin
				coord_t a [6];
				foreach (a[i]) a[i] = coord_t'($urandom);
				set_box(a[0], a[1], a[2], a[3], a[4], a[5]);
			end
			endcase
			for (int i = 0; i < NRAND / 5; i++) begin
				r = random_ray(ph == 0 || $urandom_range(0, 4) == 0);
				ray_queue.push_back(r);
			end
			// Long receiver stall while requests keep coming.
			if (ph == 1) hold_off = 200;
			drain();
		end

		$display("covered %0d rays over 8 box settings, %0d hits", results_seen, hits_seen);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/rbst_pkg.sv
hdl/rbst_axis.sv
hdl/rbst_cross.sv
hdl/ray_box_slab_test.sv
tb/ray_box_slab_test_tb.sv
